[hdl/dhfk_pkg.sv]
// Shared types, constants and rounding helper for the DH forward kinematics block.
// No dependencies.
package dhfk_pkg;

    localparam int ANG_W      = 17;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int POS_W      = 19;
    localparam int TRIG_W     = 18;
    localparam int XY_W       = 20;
    localparam int Z_W        = 25;
    localparam int WRAP_W     = 16;
    localparam int REST_W     = 14;
    localparam int PT_W       = 32;
    localparam int PROD_W     = PT_W + TRIG_W;
    localparam int TRIG_FRAC  = 16;
    localparam int POS_FRAC   = 8;

    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_LAT     = CORDIC_STEPS + 3;
    localparam int JOINT_LAT    = 4;
    localparam int PIPE_LAT     = TRIG_LAT + 3 * JOINT_LAT + 1;

    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 20'sd39797;
    localparam logic signed [XY_W-1:0]  TRIG_ONE    = 20'sd65536;
    localparam logic signed [PT_W-1:0]  POS_LIMIT   = 32'sd196608;

    localparam logic signed [Z_W-1:0] ATAN [CORDIC_STEPS] = '{
        25'sd4500000, 25'sd2656505, 25'sd1403624, 25'sd712502,
        25'sd357633,  25'sd178991,  25'sd89517,   25'sd44761,
        25'sd22381,   25'sd11191,   25'sd5595,    25'sd2798,
        25'sd1399,    25'sd699,     25'sd350,     25'sd175
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_ONE   = 4'd0,
        REG_OFFSET_TWO   = 4'd1,
        REG_OFFSET_THREE = 4'd2,
        REG_LENGTH_ONE   = 4'd3,
        REG_LENGTH_TWO   = 4'd4,
        REG_LENGTH_THREE = 4'd5,
        REG_TWIST_ONE    = 4'd6,
        REG_TWIST_TWO    = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } point_t;

    // floor((prod + 2^15) / 2^16), result kept to the point width
    function automatic logic signed [PT_W-1:0] tmul_round(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] t;
        t = prod + $signed({{(PROD_W-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}});
        return t[PT_W+TRIG_FRAC-1:TRIG_FRAC];
    endfunction

endpackage

[hdl/dhfk_trig.sv]
// Pipelined cosine/sine: angle wrap, quadrant split, 16-stage rotation CORDIC.
// Depends on dhfk_pkg.
module dhfk_trig (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [dhfk_pkg::ANG_W-1:0]   angle,
    output dhfk_pkg::trig_t                     cs
);

    logic signed [dhfk_pkg::ANG_W+1:0]  shifted;
    logic [dhfk_pkg::WRAP_W-1:0]        wrap_next, wrap_reg;
    logic [dhfk_pkg::REST_W-1:0]        rest_next;
    dhfk_pkg::quad_t                    quad_next;
    logic signed [dhfk_pkg::Z_W-1:0]    z0_next;
    logic signed [dhfk_pkg::XY_W-1:0]   x_reg [dhfk_pkg::CORDIC_STEPS+1];
    logic signed [dhfk_pkg::XY_W-1:0]   y_reg [dhfk_pkg::CORDIC_STEPS+1];
    logic signed [dhfk_pkg::Z_W-1:0]    z_reg [dhfk_pkg::CORDIC_STEPS+1];
    dhfk_pkg::quad_t                    quad_reg [dhfk_pkg::CORDIC_STEPS+1];
    logic signed [dhfk_pkg::TRIG_W-1:0] cc, ss;
    dhfk_pkg::trig_t                    cs_next, cs_reg;

    function automatic logic signed [dhfk_pkg::TRIG_W-1:0] clamp_trig(
        input logic signed [dhfk_pkg::XY_W-1:0] v
    );
        logic signed [dhfk_pkg::XY_W-1:0] r;
        if (v > dhfk_pkg::TRIG_ONE) begin
            r = dhfk_pkg::TRIG_ONE;
        end else if (v < -dhfk_pkg::TRIG_ONE) begin
            r = -dhfk_pkg::TRIG_ONE;
        end else begin
            r = v;
        end
        return r[dhfk_pkg::TRIG_W-1:0];
    endfunction

    // wrap into [0, 36000): bias by two turns, then take off 0..3 turns
    always_comb begin
        shifted = 19'(angle) + 19'sd72000;
        if (shifted >= 19'sd108000) begin
            wrap_next = dhfk_pkg::WRAP_W'(shifted - 19'sd108000);
        end else if (shifted >= 19'sd72000) begin
            wrap_next = dhfk_pkg::WRAP_W'(shifted - 19'sd72000);
        end else if (shifted >= 19'sd36000) begin
            wrap_next = dhfk_pkg::WRAP_W'(shifted - 19'sd36000);
        end else begin
            wrap_next = dhfk_pkg::WRAP_W'(shifted);
        end
    end

    always_comb begin
        if (wrap_reg >= 16'd27000) begin
            quad_next = dhfk_pkg::QUAD_3;
            rest_next = dhfk_pkg::REST_W'(wrap_reg - 16'd27000);
        end else if (wrap_reg >= 16'd18000) begin
            quad_next = dhfk_pkg::QUAD_2;
            rest_next = dhfk_pkg::REST_W'(wrap_reg - 16'd18000);
        end else if (wrap_reg >= 16'd9000) begin
            quad_next = dhfk_pkg::QUAD_1;
            rest_next = dhfk_pkg::REST_W'(wrap_reg - 16'd9000);
        end else begin
            quad_next = dhfk_pkg::QUAD_0;
            rest_next = dhfk_pkg::REST_W'(wrap_reg);
        end
        z0_next = $signed({1'b0, 24'(rest_next) * 24'd1000});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg    <= wrap_next;
            x_reg[0]    <= dhfk_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            quad_reg[0] <= quad_next;
        end
    end

    for (genvar k = 0; k < dhfk_pkg::CORDIC_STEPS; k++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[k][dhfk_pkg::Z_W-1]) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - dhfk_pkg::ATAN[k];
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + dhfk_pkg::ATAN[k];
                end
                quad_reg[k+1] <= quad_reg[k];
            end
        end
    end

    always_comb begin
        cc = clamp_trig(x_reg[dhfk_pkg::CORDIC_STEPS]);
        ss = clamp_trig(y_reg[dhfk_pkg::CORDIC_STEPS]);
        unique case (quad_reg[dhfk_pkg::CORDIC_STEPS])
            dhfk_pkg::QUAD_0: begin
                cs_next.c = cc;
                cs_next.s = ss;
            end
            dhfk_pkg::QUAD_1: begin
                cs_next.c = -ss;
                cs_next.s = cc;
            end
            dhfk_pkg::QUAD_2: begin
                cs_next.c = -cc;
                cs_next.s = -ss;
            end
            default: begin
                cs_next.c = ss;
                cs_next.s = -cc;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cs_reg <= cs_next;
        end
    end

    assign cs = cs_reg;

endmodule

[hdl/dhfk_joint.sv]
// One DH joint: rotate about x by twist, add link length, rotate about z, add offset.
// Four register stages. Depends on dhfk_pkg.
module dhfk_joint (
    input  logic                                aclk,
    input  logic                                en,
    input  dhfk_pkg::point_t                    p_in,
    input  dhfk_pkg::trig_t                     theta,
    input  dhfk_pkg::trig_t                     twist,
    input  logic signed [dhfk_pkg::CFG_W-1:0]   link_len,
    input  logic signed [dhfk_pkg::CFG_W-1:0]   link_off,
    output dhfk_pkg::point_t                    p_out
);

    logic signed [dhfk_pkg::PROD_W-1:0] yca_reg, zsa_reg, ysa_reg, zca_reg;
    logic signed [dhfk_pkg::PROD_W-1:0] hc_reg, us_reg, hs_reg, uc_reg;
    logic signed [dhfk_pkg::PT_W-1:0]   px1_reg, w3_reg;
    logic signed [dhfk_pkg::PT_W-1:0]   u_next, w_next, h_next;
    logic signed [dhfk_pkg::PT_W-1:0]   u_reg, w_reg, h_reg;
    dhfk_pkg::trig_t                    th1_reg, th2_reg;
    dhfk_pkg::point_t                   p_next, p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            yca_reg <= p_in.y * twist.c;
            zsa_reg <= p_in.z * twist.s;
            ysa_reg <= p_in.y * twist.s;
            zca_reg <= p_in.z * twist.c;
            px1_reg <= p_in.x;
            th1_reg <= theta;
        end
    end

    always_comb begin
        u_next = dhfk_pkg::tmul_round(yca_reg) - dhfk_pkg::tmul_round(zsa_reg);
        w_next = dhfk_pkg::tmul_round(ysa_reg) + dhfk_pkg::tmul_round(zca_reg);
        h_next = px1_reg + {{(dhfk_pkg::PT_W-dhfk_pkg::CFG_W-dhfk_pkg::POS_FRAC){link_len[dhfk_pkg::CFG_W-1]}},
                            link_len, {dhfk_pkg::POS_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg   <= u_next;
            w_reg   <= w_next;
            h_reg   <= h_next;
            th2_reg <= th1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hc_reg <= h_reg * th2_reg.c;
            us_reg <= u_reg * th2_reg.s;
            hs_reg <= h_reg * th2_reg.s;
            uc_reg <= u_reg * th2_reg.c;
            w3_reg <= w_reg;
        end
    end

    always_comb begin
        p_next.x = dhfk_pkg::tmul_round(hc_reg) - dhfk_pkg::tmul_round(us_reg);
        p_next.y = dhfk_pkg::tmul_round(hs_reg) + dhfk_pkg::tmul_round(uc_reg);
        p_next.z = w3_reg + {{(dhfk_pkg::PT_W-dhfk_pkg::CFG_W-dhfk_pkg::POS_FRAC){link_off[dhfk_pkg::CFG_W-1]}},
                             link_off, {dhfk_pkg::POS_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p_out = p_reg;

endmodule

[hdl/dh_forward_kinematics_3dof.sv]
// Top level: register file, five trig pipelines, three joint stages, output rounding.
// Depends on dhfk_pkg, dhfk_trig, dhfk_joint.
//
//   channel  | valid / ready         | payload
//   ---------+-----------------------+----------------------------------------------
//   s_       | s_valid / s_ready     | s_base_angle, s_shoulder_angle, s_elbow_angle
//   m_       | m_valid / m_ready     | m_pos_x, m_pos_y, m_pos_z
//   cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle unless stalled; stages: trig, joints, output rounding.
// The whole pipeline advances together whenever the output slot is empty or taken.
// Reset clears all valid bits and loads register defaults; cfg_ready is always high.
// A stall freezes every stage, so nothing is dropped or duplicated.
module dh_forward_kinematics_3dof (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dhfk_pkg::ANG_W-1:0]   s_base_angle,
    input  logic signed [dhfk_pkg::ANG_W-1:0]   s_shoulder_angle,
    input  logic signed [dhfk_pkg::ANG_W-1:0]   s_elbow_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dhfk_pkg::POS_W-1:0]   m_pos_x,
    output logic signed [dhfk_pkg::POS_W-1:0]   m_pos_y,
    output logic signed [dhfk_pkg::POS_W-1:0]   m_pos_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhfk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [dhfk_pkg::CFG_W-1:0]   cfg_data
);

    logic signed [dhfk_pkg::CFG_W-1:0] off1_reg, off2_reg, off3_reg;
    logic signed [dhfk_pkg::CFG_W-1:0] len1_reg, len2_reg, len3_reg;
    logic signed [dhfk_pkg::CFG_W-1:0] tw1_reg, tw2_reg;
    logic                              en;
    logic [dhfk_pkg::PIPE_LAT-1:0]     vld_reg, vld_next;
    dhfk_pkg::trig_t                   th1_cs, th2_cs, th3_cs, tw1_cs, tw2_cs;
    dhfk_pkg::trig_t                   th1_dly_reg [2*dhfk_pkg::JOINT_LAT];
    dhfk_pkg::trig_t                   tw1_dly_reg [2*dhfk_pkg::JOINT_LAT];
    dhfk_pkg::trig_t                   th2_dly_reg [dhfk_pkg::JOINT_LAT];
    dhfk_pkg::trig_t                   tw2_dly_reg [dhfk_pkg::JOINT_LAT];
    dhfk_pkg::point_t                  p3, p2, p1;
    logic signed [dhfk_pkg::POS_W-1:0] px_next, py_next, pz_next;
    logic signed [dhfk_pkg::POS_W-1:0] px_reg, py_reg, pz_reg;

    function automatic logic signed [dhfk_pkg::POS_W-1:0] round_sat(
        input logic signed [dhfk_pkg::PT_W-1:0] v
    );
        logic signed [dhfk_pkg::PT_W-1:0] r;
        r = (v + 32'sd128) >>> dhfk_pkg::POS_FRAC;
        if (r > dhfk_pkg::POS_LIMIT) begin
            r = dhfk_pkg::POS_LIMIT;
        end else if (r < -dhfk_pkg::POS_LIMIT) begin
            r = -dhfk_pkg::POS_LIMIT;
        end
        return r[dhfk_pkg::POS_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off1_reg <= 16'sd1280;
            off2_reg <= 16'sd0;
            off3_reg <= 16'sd0;
            len1_reg <= 16'sd0;
            len2_reg <= 16'sd768;
            len3_reg <= 16'sd512;
            tw1_reg  <= 16'sd9000;
            tw2_reg  <= 16'sd0;
        end else if (cfg_valid) begin
            unique case (dhfk_pkg::cfg_reg_t'(cfg_index))
                dhfk_pkg::REG_OFFSET_ONE:   off1_reg <= cfg_data;
                dhfk_pkg::REG_OFFSET_TWO:   off2_reg <= cfg_data;
                dhfk_pkg::REG_OFFSET_THREE: off3_reg <= cfg_data;
                dhfk_pkg::REG_LENGTH_ONE:   len1_reg <= cfg_data;
                dhfk_pkg::REG_LENGTH_TWO:   len2_reg <= cfg_data;
                dhfk_pkg::REG_LENGTH_THREE: len3_reg <= cfg_data;
                dhfk_pkg::REG_TWIST_ONE:    tw1_reg  <= cfg_data;
                dhfk_pkg::REG_TWIST_TWO:    tw2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid = vld_reg[dhfk_pkg::PIPE_LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        vld_next = {vld_reg[dhfk_pkg::PIPE_LAT-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    dhfk_trig u_trig_th1 (.aclk(aclk), .en(en), .angle(s_base_angle),     .cs(th1_cs));
    dhfk_trig u_trig_th2 (.aclk(aclk), .en(en), .angle(s_shoulder_angle), .cs(th2_cs));
    dhfk_trig u_trig_th3 (.aclk(aclk), .en(en), .angle(s_elbow_angle),    .cs(th3_cs));
    dhfk_trig u_trig_tw1 (.aclk(aclk), .en(en), .angle(17'(tw1_reg)),     .cs(tw1_cs));
    dhfk_trig u_trig_tw2 (.aclk(aclk), .en(en), .angle(17'(tw2_reg)),     .cs(tw2_cs));

    // line up joint one and two angles with the point coming out of the later joints
    always_ff @(posedge aclk) begin
        if (en) begin
            th1_dly_reg[0] <= th1_cs;
            tw1_dly_reg[0] <= tw1_cs;
            th2_dly_reg[0] <= th2_cs;
            tw2_dly_reg[0] <= tw2_cs;
            for (int i = 1; i < 2*dhfk_pkg::JOINT_LAT; i++) begin
                th1_dly_reg[i] <= th1_dly_reg[i-1];
                tw1_dly_reg[i] <= tw1_dly_reg[i-1];
            end
            for (int i = 1; i < dhfk_pkg::JOINT_LAT; i++) begin
                th2_dly_reg[i] <= th2_dly_reg[i-1];
                tw2_dly_reg[i] <= tw2_dly_reg[i-1];
            end
        end
    end

    // joint three starts from the origin, so its twist term is zero
    dhfk_joint u_joint3 (
        .aclk(aclk), .en(en), .p_in('0), .theta(th3_cs), .twist('0),
        .link_len(len3_reg), .link_off(off3_reg), .p_out(p3)
    );

    dhfk_joint u_joint2 (
        .aclk(aclk), .en(en), .p_in(p3),
        .theta(th2_dly_reg[dhfk_pkg::JOINT_LAT-1]),
        .twist(tw2_dly_reg[dhfk_pkg::JOINT_LAT-1]),
        .link_len(len2_reg), .link_off(off2_reg), .p_out(p2)
    );

    dhfk_joint u_joint1 (
        .aclk(aclk), .en(en), .p_in(p2),
        .theta(th1_dly_reg[2*dhfk_pkg::JOINT_LAT-1]),
        .twist(tw1_dly_reg[2*dhfk_pkg::JOINT_LAT-1]),
        .link_len(len1_reg), .link_off(off1_reg), .p_out(p1)
    );

    always_comb begin
        px_next = round_sat(p1.x);
        py_next = round_sat(p1.y);
        pz_next = round_sat(p1.z);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    assign m_pos_x = px_reg;
    assign m_pos_y = py_reg;
    assign m_pos_z = pz_reg;

`ifndef ASSERT_OFF
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction not in first stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pos_x <= 19'sd196608) && (m_pos_x >= -19'sd196608)
                 && (m_pos_y <= 19'sd196608) && (m_pos_y >= -19'sd196608)
                 && (m_pos_z <= 19'sd196608) && (m_pos_z >= -19'sd196608))
        else $error("position outside saturation range");
`endif

endmodule
